### rtl/ipv4_header_parse_check_defines.svh
// assertion macros for the ipv4 header parse and check block
// used by the top level only, no other dependencies
`ifndef IPV4_HEADER_PARSE_CHECK_DEFINES_SVH
`define IPV4_HEADER_PARSE_CHECK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPV4HPC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipv4hpc assertion failed");

// next-cycle implication, disabled during reset
`define IPV4HPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipv4hpc assertion failed");

`endif

### rtl/ipv4hpc_pkg.sv
// shared types and constants for the ipv4 header parse and check block
// no dependencies
package ipv4hpc_pkg;

    // longest packet the byte counter tracks, counter saturates here
    localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;

    // header length limits in bytes
    localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
    localparam logic [5:0] MAX_HDR_BYTES = 6'd60;
    localparam logic [3:0] IPV4_VERSION  = 4'd4;

    // header byte offsets
    localparam logic [15:0] OFS_VER_IHL  = 16'd0;
    localparam logic [15:0] OFS_TOTAL_HI = 16'd2;
    localparam logic [15:0] OFS_TOTAL_LO = 16'd3;
    localparam logic [15:0] OFS_IDENT_HI = 16'd4;
    localparam logic [15:0] OFS_IDENT_LO = 16'd5;
    localparam logic [15:0] OFS_FRAG_HI  = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO  = 16'd7;
    localparam logic [15:0] OFS_TTL      = 16'd8;
    localparam logic [15:0] OFS_PROTO    = 16'd9;
    localparam logic [15:0] OFS_SRC_0    = 16'd12;
    localparam logic [15:0] OFS_SRC_1    = 16'd13;
    localparam logic [15:0] OFS_SRC_2    = 16'd14;
    localparam logic [15:0] OFS_SRC_3    = 16'd15;
    localparam logic [15:0] OFS_DST_0    = 16'd16;
    localparam logic [15:0] OFS_DST_1    = 16'd17;
    localparam logic [15:0] OFS_DST_2    = 16'd18;
    localparam logic [15:0] OFS_DST_3    = 16'd19;

    // verdict codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_HDR_LEN   = 3'd3;
    localparam logic [2:0] ERR_TOTAL_LEN = 3'd4;
    localparam logic [2:0] ERR_FRAGMENT  = 3'd5;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd6;

    // stream state after the current word is folded in
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] sum;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [15:0] ident;
        logic [15:0] frag;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } hdr_state_t;

    // one verdict
    typedef struct packed {
        logic        accepted;
        logic [2:0]  error_code;
        logic [3:0]  header_words;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [15:0] ident_value;
        logic [15:0] frag_offset_bytes;
        logic        more_frags;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] payload_bytes;
    } result_t;

endpackage

### rtl/ipv4hpc_accum.sv
// header field capture, byte counter and one's complement header sum
// depends on ipv4hpc_pkg
module ipv4hpc_accum (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    byte_fire,
    input  logic [7:0]              data_byte,
    input  logic                    last_flag,
    output ipv4hpc_pkg::hdr_state_t hdr_state
);
    import ipv4hpc_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [5:0]  hdr_len;
    logic [16:0] sum_wide;

    // field capture by byte position
    always_comb begin
        ver_ihl_next   = ver_ihl_reg;
        total_len_next = total_len_reg;
        ident_next     = ident_reg;
        frag_next      = frag_reg;
        ttl_next       = ttl_reg;
        proto_next     = proto_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        unique case (byte_count_reg)
            OFS_VER_IHL: ver_ihl_next = data_byte;
            OFS_TOTAL_HI, OFS_TOTAL_LO: total_len_next = {total_len_reg[7:0], data_byte};
            OFS_IDENT_HI, OFS_IDENT_LO: ident_next = {ident_reg[7:0], data_byte};
            OFS_FRAG_HI, OFS_FRAG_LO: frag_next = {frag_reg[7:0], data_byte};
            OFS_TTL: ttl_next = data_byte;
            OFS_PROTO: proto_next = data_byte;
            OFS_SRC_0, OFS_SRC_1, OFS_SRC_2, OFS_SRC_3: begin
                src_next = {src_reg[23:0], data_byte};
            end
            OFS_DST_0, OFS_DST_1, OFS_DST_2, OFS_DST_3: begin
                dst_next = {dst_reg[23:0], data_byte};
            end
            default: begin
            end
        endcase
    end

    // header sum over big-endian words with end-around carry
    always_comb begin
        hdr_len   = {ver_ihl_next[3:0], 2'b00};
        hold_next = hold_reg;
        sum_next  = sum_reg;
        sum_wide  = {1'b0, sum_reg} + {1'b0, hold_reg, data_byte};
        if (byte_count_reg < {10'd0, hdr_len}) begin
            if (!byte_count_reg[0]) begin
                hold_next = data_byte;
            end else begin
                sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end
    end

    // saturating byte counter
    assign byte_count_next = (byte_count_reg != MAX_PACKET_BYTES) ?
                             byte_count_reg + 16'd1 : byte_count_reg;

    // updated state goes to the checker
    assign hdr_state.byte_count = byte_count_next;
    assign hdr_state.sum        = sum_next;
    assign hdr_state.ver_ihl    = ver_ihl_next;
    assign hdr_state.total_len  = total_len_next;
    assign hdr_state.ident      = ident_next;
    assign hdr_state.frag       = frag_next;
    assign hdr_state.ttl        = ttl_next;
    assign hdr_state.proto      = proto_next;
    assign hdr_state.src        = src_next;
    assign hdr_state.dst        = dst_next;

    // stream state, cleared on reset and after each last word
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_fire && last_flag)) begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            hold_reg       <= '0;
            ver_ihl_reg    <= '0;
            total_len_reg  <= '0;
            ident_reg      <= '0;
            frag_reg       <= '0;
            ttl_reg        <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
        end else if (byte_fire) begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            hold_reg       <= hold_next;
            ver_ihl_reg    <= ver_ihl_next;
            total_len_reg  <= total_len_next;
            ident_reg      <= ident_next;
            frag_reg       <= frag_next;
            ttl_reg        <= ttl_next;
            proto_reg      <= proto_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
        end
    end

endmodule

### rtl/ipv4hpc_check.sv
// header checks and verdict formation
// depends on ipv4hpc_pkg
module ipv4hpc_check (
    input  ipv4hpc_pkg::hdr_state_t hdr_state,
    output ipv4hpc_pkg::result_t    verdict
);
    import ipv4hpc_pkg::*;

    logic [5:0]  hdr_len;
    logic [15:0] hdr_len_w;
    logic [15:0] frag_off;
    logic        more;
    logic [15:0] payload;
    logic [16:0] lim_hdr;
    logic [16:0] lim_total;
    logic        frag_bad;
    logic [2:0]  code;

    // derived lengths
    assign hdr_len   = {hdr_state.ver_ihl[3:0], 2'b00};
    assign hdr_len_w = {10'd0, hdr_len};
    assign frag_off  = {hdr_state.frag[12:0], 3'b000};
    assign more      = hdr_state.frag[13];
    assign payload   = (hdr_state.total_len >= hdr_len_w) ?
                       hdr_state.total_len - hdr_len_w : 16'd0;

    // fragment offset limits
    assign lim_hdr   = {1'b0, MAX_PACKET_BYTES} - {1'b0, hdr_len_w};
    assign lim_total = {1'b0, MAX_PACKET_BYTES} - {1'b0, hdr_state.total_len}
                       + {1'b0, hdr_len_w};
    assign frag_bad  = ({1'b0, frag_off} > lim_hdr) || ({1'b0, frag_off} > lim_total) ||
                       (more && (payload == 16'd0)) || (more && (payload[2:0] != 3'd0));

    // first failing check gives the code
    always_comb begin
        priority if (hdr_state.byte_count < {10'd0, MIN_HDR_BYTES}) begin
            code = ERR_SHORT;
        end else if (hdr_state.ver_ihl[7:4] != IPV4_VERSION) begin
            code = ERR_VERSION;
        end else if (hdr_len < MIN_HDR_BYTES || hdr_len > MAX_HDR_BYTES ||
                     hdr_len_w > hdr_state.byte_count) begin
            code = ERR_HDR_LEN;
        end else if (hdr_state.total_len < hdr_len_w ||
                     hdr_state.total_len > hdr_state.byte_count) begin
            code = ERR_TOTAL_LEN;
        end else if (frag_bad) begin
            code = ERR_FRAGMENT;
        end else if (hdr_state.sum != 16'hFFFF) begin
            code = ERR_CHECKSUM;
        end else begin
            code = ERR_OK;
        end
    end

    // fields only on a passing header
    always_comb begin
        verdict            = '0;
        verdict.error_code = code;
        if (code == ERR_OK) begin
            verdict.accepted          = 1'b1;
            verdict.header_words      = hdr_state.ver_ihl[3:0];
            verdict.time_to_live      = hdr_state.ttl;
            verdict.protocol_number   = hdr_state.proto;
            verdict.ident_value       = hdr_state.ident;
            verdict.frag_offset_bytes = frag_off;
            verdict.more_frags        = more;
            verdict.source_address    = hdr_state.src;
            verdict.dest_address      = hdr_state.dst;
            verdict.payload_bytes     = payload;
        end
    end

endmodule

### rtl/ipv4_header_parse_check.sv
// ipv4 header parse and check, one packet byte per word
// a last byte is held in the input register, then its verdict is loaded into the result register
// throughput: one byte per cycle while the input does not stall, set by the input register feeding the update logic
// one verdict per packet; the input stalls only on a last byte while a verdict waits
// reset (aresetn, synchronous, active low) clears all stream state and both valid flags
module ipv4_header_parse_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_error_code,
    output logic [3:0]  m_header_words,
    output logic [7:0]  m_time_to_live,
    output logic [7:0]  m_protocol_number,
    output logic [15:0] m_ident_value,
    output logic [15:0] m_frag_offset_bytes,
    output logic        m_more_frags,
    output logic [31:0] m_source_address,
    output logic [31:0] m_dest_address,
    output logic [15:0] m_payload_bytes
);
    import ipv4hpc_pkg::*;

    `include "ipv4_header_parse_check_defines.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       proc_fire;
    logic       verdict_fire;
    hdr_state_t hdr_state;
    result_t    verdict;

    // a byte moves on unless it is a last byte and the result slot is full and not being taken
    assign proc_fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign verdict_fire = proc_fire && in_last_reg;
    assign s_ready      = !in_valid_reg || proc_fire;

    // input register
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !proc_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_packet_byte;
            in_last_reg <= s_last_byte;
        end
    end

    ipv4hpc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (proc_fire),
        .data_byte (in_byte_reg),
        .last_flag (in_last_reg),
        .hdr_state (hdr_state)
    );

    ipv4hpc_check u_check (
        .hdr_state (hdr_state),
        .verdict   (verdict)
    );

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (verdict_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (verdict_fire) begin
            out_reg <= verdict;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_accepted          = out_reg.accepted;
    assign m_error_code        = out_reg.error_code;
    assign m_header_words      = out_reg.header_words;
    assign m_time_to_live      = out_reg.time_to_live;
    assign m_protocol_number   = out_reg.protocol_number;
    assign m_ident_value       = out_reg.ident_value;
    assign m_frag_offset_bytes = out_reg.frag_offset_bytes;
    assign m_more_frags        = out_reg.more_frags;
    assign m_source_address    = out_reg.source_address;
    assign m_dest_address      = out_reg.dest_address;
    assign m_payload_bytes     = out_reg.payload_bytes;

    // checks on the block's own control
    `IPV4HPC_ASSERT_NEXT(a_verdict_loaded, aclk, aresetn, verdict_fire, out_valid_reg)
    `IPV4HPC_ASSERT_NOW(a_stall_only_on_last, aclk, aresetn, !s_ready, in_valid_reg && in_last_reg && out_valid_reg && !m_ready)
    `IPV4HPC_ASSERT_NOW(a_accept_matches_code, aclk, aresetn, out_valid_reg, out_reg.accepted == (out_reg.error_code == ERR_OK))
    `IPV4HPC_ASSERT_NOW(a_reject_clears_fields, aclk, aresetn, out_valid_reg && !out_reg.accepted, out_reg.source_address == 32'd0 && out_reg.payload_bytes == 16'd0)

endmodule
